// ===== rtl/pvd_pkg.sv =====
package pvd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned MaxLead = 4;

  localparam logic [WordW-1:0] Mask1 = 32'h0000_007f;
  localparam logic [WordW-1:0] Mask2 = 32'h0000_3fff;
  localparam logic [WordW-1:0] Mask3 = 32'h001f_ffff;
  localparam logic [WordW-1:0] Mask4 = 32'h0fff_ffff;
  localparam logic [WordW-1:0] Mask5 = 32'hffff_ffff;

  // one decoded result as it leaves the core
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] value;
    logic [LenW-1:0]  length;
    logic             error;
  } pvd_res_t;

  // leading ones of the first byte, capped at four
  function automatic logic [LenW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    casez (b[7:4])
      4'b0???: n = 3'd0;
      4'b10??: n = 3'd1;
      4'b110?: n = 3'd2;
      4'b1110: n = 3'd3;
      default: n = 3'(MaxLead);
    endcase
    return n;
  endfunction

  // payload mask by total byte count
  function automatic logic [WordW-1:0] form_mask(input logic [LenW-1:0] len);
    logic [WordW-1:0] m;
    case (len)
      3'd1:    m = Mask1;
      3'd2:    m = Mask2;
      3'd3:    m = Mask3;
      3'd4:    m = Mask4;
      default: m = Mask5;
    endcase
    return m;
  endfunction

  // mask and optional zigzag mapping
  function automatic logic [WordW-1:0] finish_word(input logic [WordW-1:0] word,
                                                   input logic [LenW-1:0]  len,
                                                   input logic             sgn);
    logic [WordW-1:0] v;
    v = word & form_mask(len);
    if (sgn) begin
      v = v[0] ? ~(v >> 1) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== rtl/pvd_core.sv =====
module pvd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [pvd_pkg::ByteW-1:0]     data_byte_i,
  input  logic                          stream_end_i,
  input  logic                          signed_mode_i,
  output pvd_pkg::pvd_res_t             res_o
);

  logic [pvd_pkg::WordW-1:0] acc_q, acc_d;
  logic [pvd_pkg::LenW-1:0]  left_q, left_d;
  logic [pvd_pkg::LenW-1:0]  total_q, total_d;
  logic [pvd_pkg::WordW-1:0] acc_shift;
  logic [pvd_pkg::LenW-1:0]  lead;

  assign acc_shift = {acc_q[pvd_pkg::WordW-pvd_pkg::ByteW-1:0], data_byte_i};
  assign lead      = pvd_pkg::lead_ones(data_byte_i);

  // decode state update and result forming
  always_comb begin
    acc_d   = acc_q;
    left_d  = left_q;
    total_d = total_q;
    res_o   = '0;
    if (step_i) begin
      if (stream_end_i) begin
        acc_d       = '0;
        left_d      = '0;
        total_d     = '0;
        res_o.valid = 1'b1;
        res_o.error = 1'b1;
      end else if (left_q == '0) begin
        if (lead == '0) begin
          acc_d        = '0;
          total_d      = '0;
          res_o.valid  = 1'b1;
          res_o.length = 3'd1;
          res_o.value  = pvd_pkg::finish_word(
                           {{(pvd_pkg::WordW-pvd_pkg::ByteW){1'b0}}, data_byte_i},
                           3'd1, signed_mode_i);
        end else begin
          acc_d   = {{(pvd_pkg::WordW-pvd_pkg::ByteW){1'b0}}, data_byte_i};
          left_d  = lead;
          total_d = lead + 3'd1;
        end
      end else begin
        left_d = left_q - 3'd1;
        if (left_q == 3'd1) begin
          acc_d        = '0;
          total_d      = '0;
          res_o.valid  = 1'b1;
          res_o.length = total_q;
          res_o.value  = pvd_pkg::finish_word(acc_shift, total_q, signed_mode_i);
        end else begin
          acc_d = acc_shift;
        end
      end
    end
  end

  // decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      left_q  <= '0;
      total_q <= '0;
    end else begin
      acc_q   <= acc_d;
      left_q  <= left_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== rtl/prefix_varint_stream_decoder.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | data_byte_i, stream_end_i
// out     | output    | out_valid_o/out_ready_i | value_o, length_o, error_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (signed_mode)
//
// one item per cycle sustained while out is not stalled; an accepted item passes
// through the input register, then decode logic into the result register
// items that end no value give no result; a stream end always gives one
// reset clears decode state, signed_mode and both valid flags
// a stall on out holds the result register and backs up through the input register
module prefix_varint_stream_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pvd_pkg::ByteW-1:0] data_byte_i,
  input  logic                      stream_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pvd_pkg::WordW-1:0] value_o,
  output logic [pvd_pkg::LenW-1:0]  length_o,
  output logic                      error_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i
);

  logic                      signed_q;
  logic                      in_vld_q;
  logic [pvd_pkg::ByteW-1:0] in_byte_q;
  logic                      in_end_q;
  logic                      out_vld_q;
  logic [pvd_pkg::WordW-1:0] out_value_q;
  logic [pvd_pkg::LenW-1:0]  out_len_q;
  logic                      out_err_q;
  logic                      out_free;
  logic                      step;
  pvd_pkg::pvd_res_t         res;

  // flow control
  assign out_free    = !out_vld_q || out_ready_i;
  assign step        = in_vld_q && out_free;
  assign in_ready_o  = !in_vld_q || out_free;
  assign cfg_ready_o = 1'b1;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_q <= 1'b0;
    end else if (cfg_valid_i) begin
      signed_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= stream_end_i;
    end
  end

  pvd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (in_byte_q),
    .stream_end_i  (in_end_q),
    .signed_mode_i (signed_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_value_q <= res.value;
      out_len_q   <= res.length;
      out_err_q   <= res.error;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = out_value_q;
  assign length_o    = out_len_q;
  assign error_o     = out_err_q;

endmodule
